/* design/dldc_pkg.sv */
// shared types, codes and constants for the dual lane divergence checker
`default_nettype none

package dldc_pkg;

  // default width of the statistics counters
  localparam int COUNT_WIDTH_DEF = 32;

  // reported counter width on the result channel
  localparam int STAT_OUT_W = 32;

  // number of statistics counters
  localparam int STAT_NUM = 6;

  // statistics counter slots
  typedef enum logic [2:0] {
    ST_DIV    = 3'd0,
    ST_REC    = 3'd1,
    ST_QUANTA = 3'd2,
    ST_MASKED = 3'd3,
    ST_INJ    = 3'd4,
    ST_CKPT   = 3'd5
  } stat_idx_t;

  // request function codes
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_QUANTUM = 1'b1;

  // action codes
  localparam logic [2:0] ACT_PROCEED   = 3'd0;
  localparam logic [2:0] ACT_ROLLBACK  = 3'd1;
  localparam logic [2:0] ACT_HALTED_OK = 3'd2;
  localparam logic [2:0] ACT_HARD_DIV  = 3'd3;
  localparam logic [2:0] ACT_BUDGET    = 3'd4;
  localparam logic [2:0] ACT_IDLE      = 3'd5;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_INSN_BUDGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CKPT_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd2;
  localparam int CFG_DATA_W = 64;

  // reset value of the retry limit
  localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;

  // retry run counter saturation point
  localparam logic [4:0] RETRY_RUN_MAX = 5'd31;

  // input request
  typedef struct packed {
    logic        func;
    logic [63:0] digest_a;
    logic [63:0] digest_b;
    logic [63:0] retired_a;
    logic [63:0] retired_b;
    logic        halted_a;
    logic        fault_injected;
  } in_t;

  // result request
  typedef struct packed {
    logic [2:0]            action;
    logic                  commit_flag;
    logic                  take_checkpoint;
    logic                  latency_valid;
    logic [63:0]           fault_latency;
    logic [63:0]           agreed_count;
    logic [STAT_OUT_W-1:0] divergence_count;
    logic [STAT_OUT_W-1:0] recovery_count;
    logic [STAT_OUT_W-1:0] quanta_count;
    logic [STAT_OUT_W-1:0] masked_count;
    logic [STAT_OUT_W-1:0] injected_count;
    logic [STAT_OUT_W-1:0] checkpoint_count;
  } out_t;

  // configuration register file contents
  typedef struct packed {
    logic [63:0] insn_budget;
    logic [31:0] checkpoint_period;
    logic [3:0]  retry_limit;
  } cfg_t;

endpackage

`default_nettype wire

/* design/dldc_cfg_regs.sv */
// configuration register file of the divergence checker
`default_nettype none

module dldc_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [dldc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [dldc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output dldc_pkg::cfg_t                        cfg
);
  import dldc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode, writes beyond the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_INSN_BUDGET: cfg_nxt.insn_budget       = cfg_wdata;
        CFG_CKPT_PERIOD: cfg_nxt.checkpoint_period = cfg_wdata[31:0];
        CFG_RETRY_LIMIT: cfg_nxt.retry_limit       = cfg_wdata[3:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.insn_budget       <= '0;
      cfg_r.checkpoint_period <= '0;
      cfg_r.retry_limit       <= RETRY_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* design/dldc_core.sv */
// run state, compare logic and statistics counters of the divergence checker
`default_nettype none

module dldc_core #(
  parameter int COUNT_WIDTH = dldc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           fire,
  input  dldc_pkg::in_t       item,
  input  dldc_pkg::cfg_t      cfg,
  output dldc_pkg::out_t      res
);
  import dldc_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // run state
  logic [63:0]            agreed_r, agreed_nxt;
  logic [4:0]             retry_r, retry_nxt;
  logic                   pend_r, pend_nxt;
  logic [63:0]            mark_r, mark_nxt;
  logic [31:0]            qsc_r, qsc_nxt;
  logic                   done_r, done_nxt;
  logic [COUNT_WIDTH-1:0] stat_r   [STAT_NUM];
  logic [COUNT_WIDTH-1:0] stat_nxt [STAT_NUM];

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
  endfunction

  // next state and result for the request in the input register
  always_comb begin
    logic [63:0] ret_max;
    logic        pend_eff;
    logic [63:0] mark_eff;
    logic [4:0]  retry_inc;

    agreed_nxt = agreed_r;
    retry_nxt  = retry_r;
    pend_nxt   = pend_r;
    mark_nxt   = mark_r;
    qsc_nxt    = qsc_r;
    done_nxt   = done_r;
    for (int i = 0; i < STAT_NUM; i++) begin
      stat_nxt[i] = stat_r[i];
    end

    ret_max   = (item.retired_a > item.retired_b) ? item.retired_a : item.retired_b;
    pend_eff  = pend_r | item.fault_injected;
    mark_eff  = item.fault_injected ? agreed_r : mark_r;
    retry_inc = (retry_r < RETRY_RUN_MAX) ? retry_r + 5'd1 : retry_r;

    res                 = '0;
    res.action          = ACT_PROCEED;
    res.fault_latency   = '0;

    if (item.func == FUNC_START) begin
      // open a new run with the initial checkpoint
      agreed_nxt = '0;
      retry_nxt  = '0;
      pend_nxt   = 1'b0;
      mark_nxt   = '0;
      qsc_nxt    = '0;
      for (int i = 0; i < STAT_NUM; i++) begin
        stat_nxt[i] = '0;
      end
      stat_nxt[ST_CKPT]   = COUNT_WIDTH'(1);
      res.take_checkpoint = 1'b1;
      if (cfg.insn_budget == 64'd0) begin
        res.action = ACT_BUDGET;
        done_nxt   = 1'b1;
      end else begin
        done_nxt   = 1'b0;
      end
    end else if (done_r) begin
      // quantum outside a run
      res.action = ACT_IDLE;
    end else begin
      // fault injection bookkeeping
      if (item.fault_injected) begin
        stat_nxt[ST_INJ] = sat_inc(stat_r[ST_INJ]);
        pend_nxt         = 1'b1;
        mark_nxt         = agreed_r;
      end
      if (item.digest_a != item.digest_b) begin
        // divergence: report latency for a pending fault, then rollback or give up
        stat_nxt[ST_DIV] = sat_inc(stat_r[ST_DIV]);
        if (pend_eff) begin
          res.fault_latency  = ret_max - mark_eff;
          res.latency_valid  = 1'b1;
          pend_nxt           = 1'b0;
        end
        retry_nxt = retry_inc;
        if (retry_inc > {1'b0, cfg.retry_limit}) begin
          res.action = ACT_HARD_DIV;
          done_nxt   = 1'b1;
        end else begin
          stat_nxt[ST_REC] = sat_inc(stat_r[ST_REC]);
          res.action       = ACT_ROLLBACK;
        end
      end else begin
        // agreement: advance and check halt, checkpoint, budget
        retry_nxt           = '0;
        stat_nxt[ST_QUANTA] = sat_inc(stat_r[ST_QUANTA]);
        agreed_nxt          = item.retired_a;
        if (pend_eff) begin
          stat_nxt[ST_MASKED] = sat_inc(stat_r[ST_MASKED]);
          pend_nxt            = 1'b0;
        end
        qsc_nxt = (qsc_r == 32'hFFFF_FFFF) ? qsc_r : qsc_r + 32'd1;
        if (item.halted_a) begin
          res.commit_flag   = 1'b1;
          res.action        = ACT_HALTED_OK;
          done_nxt          = 1'b1;
        end else begin
          if (cfg.checkpoint_period != 32'd0 && qsc_nxt >= cfg.checkpoint_period) begin
            res.commit_flag     = 1'b1;
            res.take_checkpoint = 1'b1;
            stat_nxt[ST_CKPT]   = sat_inc(stat_r[ST_CKPT]);
            qsc_nxt             = '0;
          end
          if (item.retired_a >= cfg.insn_budget) begin
            res.action = ACT_BUDGET;
            done_nxt   = 1'b1;
          end
        end
      end
    end

    // counters after the request
    res.agreed_count     = agreed_nxt;
    res.divergence_count = STAT_OUT_W'(stat_nxt[ST_DIV]);
    res.recovery_count   = STAT_OUT_W'(stat_nxt[ST_REC]);
    res.quanta_count     = STAT_OUT_W'(stat_nxt[ST_QUANTA]);
    res.masked_count     = STAT_OUT_W'(stat_nxt[ST_MASKED]);
    res.injected_count   = STAT_OUT_W'(stat_nxt[ST_INJ]);
    res.checkpoint_count = STAT_OUT_W'(stat_nxt[ST_CKPT]);
  end

  // state update on each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agreed_r <= '0;
      retry_r  <= '0;
      pend_r   <= 1'b0;
      mark_r   <= '0;
      qsc_r    <= '0;
      done_r   <= 1'b1;
      for (int i = 0; i < STAT_NUM; i++) begin
        stat_r[i] <= '0;
      end
    end else if (fire) begin
      agreed_r <= agreed_nxt;
      retry_r  <= retry_nxt;
      pend_r   <= pend_nxt;
      mark_r   <= mark_nxt;
      qsc_r    <= qsc_nxt;
      done_r   <= done_nxt;
      for (int i = 0; i < STAT_NUM; i++) begin
        stat_r[i] <= stat_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

/* design/dual_lane_divergence_checker.sv */
// Dual lane divergence checker, top level.
// Compares two redundant execution lanes one quantum at a time and tells the
// lane controller whether to proceed, roll back, stop on halt, stop on hard
// divergence or stop on an exhausted instruction budget.
// Input channel in_valid/in_stall/in_data carries start and quantum requests;
// result channel out_valid/out_stall/out_data returns exactly one result per
// request, in order. A request is taken when valid is high and stall is low.
// Configuration (budget, checkpoint period, retry limit) is written through
// cfg_we/cfg_idx/cfg_wdata; the user must write it only while no request is
// in flight, which the block does not enforce. An accepted request passes the
// input register, then the compare and count logic into the result register.
// Throughput: one request per cycle, limited only by the result register.
// When the receiver stalls, the result is held and one more request waits in
// the input register; after that in_stall rises until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, clears all counters,
// loads the configuration defaults and leaves the block idle until a start
// request opens a run.
`default_nettype none

module dual_lane_divergence_checker #(
  parameter int COUNT_WIDTH = dldc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // request channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  dldc_pkg::in_t                         in_data,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output dldc_pkg::out_t                        out_data,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [dldc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [dldc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dldc_pkg::*;

  cfg_t cfg;
  in_t  in_r;
  logic in_valid_r;
  out_t out_r;
  out_t res;
  logic out_valid_r;
  logic adv;

  // configuration registers
  dldc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // request moves into the result register when that slot is free
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  // compare and count logic
  dldc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (in_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* design/dldc_checker.sv */
// port level checks for the divergence checker, bound to the top level
`default_nettype none

module dldc_checker (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input dldc_pkg::out_t out_data
);
  import dldc_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a detection latency only comes with a divergence outcome
  a_latency_on_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.latency_valid |->
      (out_data.action == ACT_ROLLBACK || out_data.action == ACT_HARD_DIV))
    else $error("latency reported without divergence");

  // halt and periodic checkpoints release output, idle results do nothing
  a_commit_rules: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action == ACT_IDLE |->
      !out_data.commit_flag && !out_data.take_checkpoint && !out_data.latency_valid)
    else $error("idle result carries side effects");

  // a request accepted into an empty block shows up once it has passed the input register
  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid && !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing after accepted request");

endmodule

bind dual_lane_divergence_checker dldc_checker u_dldc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
